// File: hw/rtl/cnv_pkg.sv
// Shared types and field widths for the streaming 2-D convolution block.
`timescale 1ns / 1ps

package cnv_pkg;

  // Fixed field widths of the streaming interface
  localparam int PIXEL_W      = 8;
  localparam int COEF_W       = 16;
  localparam int COEF_INDEX_W = 5;
  localparam int FILT_W       = 29;
  localparam int SIZE_CFG_W   = 12;

  // Image size after reset
  localparam int IMAGE_SIZE_RST = 2048;

  // Input transaction kind
  typedef enum logic {
    OP_COEF  = 1'b0,
    OP_PIXEL = 1'b1
  } op_e;

endpackage

// File: hw/rtl/conv2d_5x5_valid_stream_core.sv
// Streaming (2R+1)x(2R+1) convolution over the valid interior of a square image.
//
// Channels: the input channel (in_valid_i / in_ready_o) carries either a kernel
// coefficient write (op_i = OP_COEF, coef_index_i, coef_value_i) or the next
// pixel of the frame in raster order (op_i = OP_PIXEL, pixel_i). The output
// channel (out_valid_o / out_ready_i) returns one Q.14 sum per interior pixel,
// with frame_last_o set on the last one of the frame. The config channel
// (cfg_valid_i / cfg_ready_o, always ready) sets the image size and restarts
// the frame counters.
// Throughput: one transaction per cycle while the output is not stalled, set by
// the line buffer memory, which reads and rewrites one column word per pixel
// with write-to-read forwarding. Pipeline: input/read register, window,
// products, row sums, output register, in that order.
// Reset: coefficients clear to zero, counters to zero, size to 2048. The line
// memory is not cleared; its contents only reach a result once written.
// Stall: when the output register holds an untaken result, the pipeline
// stages fill behind it and in_ready_o drops once every stage is occupied.
`timescale 1ns / 1ps

module conv2d_5x5_valid_stream_core #(
  parameter int MAX_WIDTH = 2048,
  parameter int RADIUS    = 2
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [cnv_pkg::SIZE_CFG_W-1:0]          cfg_image_size_i,
  // input stream
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    op_i,
  input  logic [cnv_pkg::COEF_INDEX_W-1:0]        coef_index_i,
  input  logic signed [cnv_pkg::COEF_W-1:0]       coef_value_i,
  input  logic [cnv_pkg::PIXEL_W-1:0]             pixel_i,
  // result stream
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [cnv_pkg::FILT_W-1:0]       filtered_o,
  output logic                                    frame_last_o
);

  localparam int K      = 2 * RADIUS + 1;
  localparam int NLINES = 2 * RADIUS;
  localparam int NCOEF  = K * K;
  localparam int CNT_W  = $clog2(MAX_WIDTH);
  localparam int CIX_W  = $clog2(NCOEF);
  localparam int PX_W   = cnv_pkg::PIXEL_W;
  localparam int LB_W   = NLINES * PX_W;
  localparam int PROD_W = PX_W + 1 + cnv_pkg::COEF_W;
  localparam int ROW_W  = PROD_W + $clog2(K);
  localparam int SUM_W  = ROW_W + $clog2(K);
  localparam int CMP_W  = (CNT_W + 1 > cnv_pkg::SIZE_CFG_W) ? CNT_W + 1 : cnv_pkg::SIZE_CFG_W;
  localparam int SZ_RST = (MAX_WIDTH < cnv_pkg::IMAGE_SIZE_RST) ? MAX_WIDTH
                                                                 : cnv_pkg::IMAGE_SIZE_RST;

  // ---------------------------------------------------------------------------
  // Handshakes and stage ready chain
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;
  logic in_fire, cfg_fire, accept_px, s1_adv;

  assign out_ready = !out_valid_q || out_ready_i;
  assign s4_ready  = !s4_valid_q || out_ready;
  assign s3_ready  = !s3_valid_q || s4_ready;
  assign s2_ready  = !s2_valid_q || s3_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;

  assign in_ready_o  = s1_ready;
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign accept_px   = in_fire && (op_i == cnv_pkg::OP_PIXEL);
  assign s1_adv      = s1_valid_q && s2_ready;

  // ---------------------------------------------------------------------------
  // Image size register, kept as the last valid index
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] szm1_q, szm1_d;
  logic [CMP_W-1:0] cfg_ext, cfg_dec;

  always_comb begin
    cfg_ext = CMP_W'(cfg_image_size_i);
    cfg_dec = cfg_ext - CMP_W'(1);
    if (cfg_ext > CMP_W'(MAX_WIDTH)) begin
      szm1_d = CNT_W'(MAX_WIDTH - 1);
    end else if (cfg_ext == '0) begin
      szm1_d = '0;
    end else begin
      szm1_d = cfg_dec[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      szm1_q <= CNT_W'(SZ_RST - 1);
    end else if (cfg_fire) begin
      szm1_q <= szm1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Raster position counters
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] col_q, row_q;
  logic             col_end, row_end, emit_d, last_d;

  assign col_end = (col_q == szm1_q);
  assign row_end = (row_q == szm1_q);
  assign emit_d  = (szm1_q >= CNT_W'(NLINES)) && (row_q >= CNT_W'(NLINES))
                   && (col_q >= CNT_W'(NLINES));
  assign last_d  = row_end && col_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_fire) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_px) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + CNT_W'(1);
      end else begin
        col_q <= col_q + CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register, line buffer read in flight
  // ---------------------------------------------------------------------------
  cnv_pkg::op_e                     s1_op_q;
  logic [cnv_pkg::COEF_INDEX_W-1:0] s1_cidx_q;
  logic signed [cnv_pkg::COEF_W-1:0] s1_cval_q;
  logic [PX_W-1:0]                  s1_px_q;
  logic [CNT_W-1:0]                 s1_col_q;
  logic                             s1_emit_q, s1_last_q;
  logic [LB_W-1:0]                  lb_rd;
  logic [LB_W-1:0]                  lb_wr_data;
  logic                             lb_wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= cnv_pkg::op_e'(op_i);
      s1_cidx_q <= coef_index_i;
      s1_cval_q <= coef_value_i;
      s1_px_q   <= pixel_i;
      s1_col_q  <= col_q;
      s1_emit_q <= emit_d;
      s1_last_q <= last_d;
    end
  end

  // column word shifts up one row; the new pixel enters the newest row
  assign lb_wr_en   = s1_adv && (s1_op_q == cnv_pkg::OP_PIXEL);
  assign lb_wr_data = {s1_px_q, lb_rd[LB_W-1:PX_W]};

  cnv_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .WORD_W (LB_W)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept_px),
    .rd_addr_i (col_q),
    .wr_en_i   (lb_wr_en),
    .wr_addr_i (s1_col_q),
    .wr_data_i (lb_wr_data),
    .rd_data_o (lb_rd)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: sliding window and coefficient store
  // ---------------------------------------------------------------------------
  logic [PX_W-1:0]                  win_q [K][K];
  logic [PX_W-1:0]                  win_d [K][K];
  logic signed [cnv_pkg::COEF_W-1:0] coef_q [NCOEF];
  logic                             s2_last_q;

  always_comb begin
    for (int a = 0; a < K; a++) begin
      for (int b = 0; b < K - 1; b++) begin
        win_d[a][b] = win_q[a][b+1];
      end
    end
    for (int a = 0; a < NLINES; a++) begin
      win_d[a][K-1] = lb_rd[a*PX_W +: PX_W];
    end
    win_d[NLINES][K-1] = s1_px_q;
  end

  always_ff @(posedge clk_i) begin
    if (lb_wr_en) begin
      win_q <= win_d;
    end
  end

  // coefficient writes land in order with the pixels around them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_q[i] <= '0;
      end
    end else if (s1_adv && (s1_op_q == cnv_pkg::OP_COEF)
                 && (s1_cidx_q < 6'(NCOEF))) begin
      coef_q[CIX_W'(s1_cidx_q)] <= s1_cval_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q && (s1_op_q == cnv_pkg::OP_PIXEL) && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_last_q <= s1_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: products
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod [K][K];
  logic signed [PROD_W-1:0] prod_q [K][K];
  logic                     s3_last_q;

  always_comb begin
    for (int a = 0; a < K; a++) begin
      for (int b = 0; b < K; b++) begin
        prod[a][b] = $signed({1'b0, win_q[a][b]}) * coef_q[a*K+b];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s3_ready) begin
      prod_q    <= prod;
      s3_last_q <= s2_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: per-row sums
  // ---------------------------------------------------------------------------
  logic signed [ROW_W-1:0] row_sum [K];
  logic signed [ROW_W-1:0] row_sum_q [K];
  logic                    s4_last_q;

  always_comb begin
    for (int a = 0; a < K; a++) begin
      row_sum[a] = '0;
      for (int b = 0; b < K; b++) begin
        row_sum[a] = row_sum[a] + ROW_W'(prod_q[a][b]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (s4_ready) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q && s4_ready) begin
      row_sum_q <= row_sum;
      s4_last_q <= s3_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: total sum, wrapped to the field width
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0]           total;
  logic signed [cnv_pkg::FILT_W-1:0] filt_q;
  logic                              last_q;

  always_comb begin
    total = '0;
    for (int a = 0; a < K; a++) begin
      total = total + SUM_W'(row_sum_q[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_valid_q && out_ready) begin
      filt_q <= total[cnv_pkg::FILT_W-1:0];
      last_q <= s4_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign filtered_o   = filt_q;
  assign frame_last_o = last_q;

endmodule

// File: hw/rtl/cnv_line_buf.sv
// Line buffer memory: one word per column holds that column of every buffered row.
`timescale 1ns / 1ps

module cnv_line_buf #(
  parameter int DEPTH  = 2048,
  parameter int WORD_W = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i,
  output logic [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read; a write to the same column in the same cycle is forwarded
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

// File: hw/rtl/cnv_checker.sv
// Port-level checks for the convolution core, bound to conv2d_5x5_valid_stream_core.
`timescale 1ns / 1ps

module cnv_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [cnv_pkg::FILT_W-1:0] filtered_o,
  input logic                              frame_last_o
);

  // A stalled result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_o)
                                    && $stable(frame_last_o))
    else $error("stalled result changed or dropped");

  // The input never stalls while the output register can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled with output free");

  // A result appearing on an empty output comes from a transaction
  // accepted exactly through the full pipeline depth earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 5))
    else $error("result without matching input transaction");

endmodule

bind conv2d_5x5_valid_stream_core cnv_checker u_cnv_checker (.*);
